>>> rtl/core/serial_can_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the deframer RTL.
// Both sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_CAN_FRAME_DEFRAMER_ASSERT_SVH
`define SERIAL_CAN_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define SCFD_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scfd: same-cycle check failed");

// Next-cycle implication.
`define SCFD_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scfd: next-cycle check failed");

`endif

>>> rtl/core/scfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_pkg
// Constants, types and the CRC step shared by the deframer modules.
// ----------------------------------------------------------------------------
package scfd_pkg;

	localparam int POS_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int NUM_DATA  = 8;

	localparam logic [7:0] START_BYTE0 = 8'hAA;
	localparam logic [7:0] START_BYTE1 = 8'h55;
	localparam logic [7:0] TRAILER0    = 8'h66;
	localparam logic [7:0] TRAILER1    = 8'hBB;
	localparam logic [7:0] PAYLOAD_LEN = 8'd11;
	localparam logic [7:0] CAN_DLC     = 8'd8;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [15:0] RST_CAN_ID   = 16'h07E0;
	localparam logic [7:0]  RST_VERSION  = 8'h01;
	localparam logic [7:0]  RST_MSG_TYPE = 8'h02;

	// frame offsets
	localparam logic [POS_W-1:0] POS_VERSION  = 5'd2;
	localparam logic [POS_W-1:0] POS_MSG_TYPE = 5'd3;
	localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd6;
	localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd7;
	localparam logic [POS_W-1:0] POS_ID_LO    = 5'd8;
	localparam logic [POS_W-1:0] POS_ID_HI    = 5'd9;
	localparam logic [POS_W-1:0] POS_DLC      = 5'd10;
	localparam logic [POS_W-1:0] POS_DATA0    = 5'd11;
	localparam logic [POS_W-1:0] POS_DATA7    = 5'd18;
	localparam logic [POS_W-1:0] POS_CRC_LO   = 5'd19;
	localparam logic [POS_W-1:0] POS_CRC_HI   = 5'd20;
	localparam logic [POS_W-1:0] POS_TRL0     = 5'd21;
	localparam logic [POS_W-1:0] POS_LAST     = 5'd22;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAN_ID   = 2'd0,
		CFG_VERSION  = 2'd1,
		CFG_MSG_TYPE = 2'd2
	} cfg_idx_t;

	// one classified frame byte, front to back
	typedef struct packed {
		logic [7:0]       data;
		logic [POS_W-1:0] pos;
		logic             fld_ok;
	} scfd_word_t;

	typedef logic [NUM_DATA-1:0][7:0] scfd_data_t;

	// CRC-16/CCITT-FALSE, one byte, msb first
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/core/scfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_front
// Start-pair hunt, byte position tracking and per-field header checks.
// ----------------------------------------------------------------------------
`include "serial_can_frame_deframer_assert.svh"

module scfd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [7:0]                      rx_byte,
	input  logic                            cfg_we,
	input  logic [scfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [scfd_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            mid_full,
	output logic                            mid_push,
	output scfd_pkg::scfd_word_t            mid_word
);
	import scfd_pkg::*;

	typedef enum logic [1:0] {
		HUNT_SOF0,
		HUNT_SOF1,
		COLLECT
	} hunt_t;

	hunt_t            state_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      can_id_q;
	logic [7:0]       version_q;
	logic [7:0]       msg_type_q;
	logic             acc;
	logic             fld_ok;

	assign acc = push && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			can_id_q   <= RST_CAN_ID;
			version_q  <= RST_VERSION;
			msg_type_q <= RST_MSG_TYPE;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_CAN_ID:   can_id_q   <= cfg_data;
				CFG_VERSION:  version_q  <= cfg_data[7:0];
				CFG_MSG_TYPE: msg_type_q <= cfg_data[7:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HUNT_SOF0;
			pos_q   <= '0;
		end else if (acc) begin
			unique case (state_q)
				HUNT_SOF0: begin
					state_q <= (rx_byte == START_BYTE0) ? HUNT_SOF1 : HUNT_SOF0;
				end
				HUNT_SOF1: begin
					if (rx_byte == START_BYTE1) begin
						state_q <= COLLECT;
						pos_q   <= POS_VERSION;
					end else begin
						state_q <= (rx_byte == START_BYTE0) ? HUNT_SOF1 : HUNT_SOF0;
					end
				end
				COLLECT: begin
					if (pos_q == POS_LAST) begin
						state_q <= HUNT_SOF0;
						pos_q   <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				default: begin
					state_q <= HUNT_SOF0;
				end
			endcase
		end
	end

	// fixed-value header and trailer fields; CRC is checked in the back end
	always_comb begin
		unique case (pos_q)
			POS_VERSION:  fld_ok = (rx_byte == version_q);
			POS_MSG_TYPE: fld_ok = (rx_byte == msg_type_q);
			POS_LEN_LO:   fld_ok = (rx_byte == PAYLOAD_LEN);
			POS_LEN_HI:   fld_ok = (rx_byte == 8'h00);
			POS_ID_LO:    fld_ok = (rx_byte == can_id_q[7:0]);
			POS_ID_HI:    fld_ok = (rx_byte == can_id_q[15:8]);
			POS_DLC:      fld_ok = (rx_byte == CAN_DLC);
			POS_TRL0:     fld_ok = (rx_byte == TRAILER0);
			POS_LAST:     fld_ok = (rx_byte == TRAILER1);
			default:      fld_ok = 1'b1;
		endcase
	end

	assign mid_push        = acc && (state_q == COLLECT);
	assign mid_word.data   = rx_byte;
	assign mid_word.pos    = pos_q;
	assign mid_word.fld_ok = fld_ok;

	`SCFD_AST_IMP(a_pos_in_frame, state_q == COLLECT, pos_q >= POS_VERSION && pos_q <= POS_LAST)
	`SCFD_AST_NXT(a_frame_end_hunts, mid_push && pos_q == POS_LAST, state_q == HUNT_SOF0)
	`SCFD_AST_IMP(a_no_push_when_full, mid_push, !mid_full)

endmodule

>>> rtl/core/scfd_mid_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_mid_q
// Two-entry queue of classified frame bytes between front and back end.
// ----------------------------------------------------------------------------
module scfd_mid_q (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  scfd_pkg::scfd_word_t  word_in,
	output logic                  full,
	input  logic                  pop,
	output scfd_pkg::scfd_word_t  word_out,
	output logic                  empty
);
	import scfd_pkg::*;

	scfd_word_t ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign word_out = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> rtl/core/scfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfd_back
// Running CRC, frame verdict, data byte capture and the result queue.
// ----------------------------------------------------------------------------
`include "serial_can_frame_deframer_assert.svh"

module scfd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  mid_empty,
	input  scfd_pkg::scfd_word_t  mid_word,
	output logic                  mid_pop,
	input  logic                  pop,
	output logic                  empty,
	output scfd_pkg::scfd_data_t  res_data
);
	import scfd_pkg::*;

	logic [15:0] crc_q;
	logic        ok_q;
	logic [7:0]  crc_lo_q;
	logic [7:0]  data_q [NUM_DATA];
	logic [2:0]  data_idx;
	logic [15:0] crc_base;
	logic [15:0] crc_nxt;
	logic        ok_base;
	logic        crc_match;
	logic        ok_nxt;
	logic        res_push;
	logic        res_full;
	logic        res_pop;

	scfd_data_t  res_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign res_full = (cnt_q == 2'd2);
	assign mid_pop  = !mid_empty && !res_full;

	// a new frame starts at the version byte
	assign crc_base  = (mid_word.pos == POS_VERSION) ? CRC_INIT : crc_q;
	assign crc_nxt   = crc16_step(crc_base, mid_word.data);
	assign ok_base   = (mid_word.pos == POS_VERSION) ? 1'b1 : ok_q;
	assign crc_match = (crc_lo_q == crc_q[7:0]) && (mid_word.data == crc_q[15:8]);
	assign ok_nxt    = ok_base && mid_word.fld_ok &&
	                   ((mid_word.pos != POS_CRC_HI) || crc_match);
	assign data_idx  = 3'(mid_word.pos - POS_DATA0);
	assign res_push  = mid_pop && (mid_word.pos == POS_LAST) && ok_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			ok_q     <= 1'b1;
			crc_lo_q <= '0;
		end else if (mid_pop) begin
			if (mid_word.pos <= POS_DATA7) crc_q <= crc_nxt;
			if (mid_word.pos == POS_CRC_LO) crc_lo_q <= mid_word.data;
			ok_q <= ok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop && mid_word.pos >= POS_DATA0 && mid_word.pos <= POS_DATA7) begin
			data_q[data_idx] <= mid_word.data;
		end
	end

	// result queue; the last data byte is already stored when the trailer arrives
	always_ff @(posedge clk) begin
		if (res_push) begin
			for (int k = 0; k < NUM_DATA; k++) begin
				res_q[wr_q][k] <= data_q[k];
			end
		end
	end

	assign res_pop  = pop && !empty;
	assign empty    = (cnt_q == 2'd0);
	assign res_data = res_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (res_push) wr_q <= ~wr_q;
			if (res_pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

	`SCFD_AST_IMP(a_res_cnt_bound, 1'b1, cnt_q <= 2'd2)
	`SCFD_AST_IMP(a_res_push_room, res_push, !res_full)
	`SCFD_AST_NXT(a_res_visible, res_push, !empty)

endmodule

>>> rtl/core/serial_can_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_can_frame_deframer
// Serial byte deframer: finds 0xAA 0x55 framed 23-byte packets, checks them,
// and returns the 8 CAN data bytes of each good frame.
// ----------------------------------------------------------------------------
// Usage:
//  - Input side is a queue write port: drive rx_byte, raise push; the byte is
//    taken on a clock edge with push high and full low.
//  - Output side is a queue read port: while empty is low, can_byte0..7 hold
//    the oldest good frame's data; pop with empty low takes that word.
//  - Throughput: one byte per clock while the result queue is not full. The
//    back end sets the pace: one bytewise CRC-16 step and verdict per byte.
//  - Result path: the edge that accepts the frame's last trailer byte puts
//    it into the middle queue; the back end then takes it from there and
//    writes the result word into the result queue, whose head drives the
//    outputs. A stalled back end holds the byte in the middle queue.
//  - Bad frames (version, type, length, CAN id, DLC, CRC or trailer wrong)
//    leave no trace on the output; the hunt restarts after byte 22 anyway.
//  - Stall: the result queue holds two words. When it is full the back end
//    stops draining the two-entry middle queue, which then raises full.
//  - Reset: hunt for 0xAA, queues empty, registers back to CAN id 0x07E0,
//    version 0x01, message type 0x02.
//  - Config: cfg_we writes cfg_data into register cfg_idx (0 CAN id, 1 version,
//    2 message type); write only while no frame is in flight.
// ----------------------------------------------------------------------------
module serial_can_frame_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      rx_byte,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      can_byte0,
	output logic [7:0]                      can_byte1,
	output logic [7:0]                      can_byte2,
	output logic [7:0]                      can_byte3,
	output logic [7:0]                      can_byte4,
	output logic [7:0]                      can_byte5,
	output logic [7:0]                      can_byte6,
	output logic [7:0]                      can_byte7,
	input  logic                            cfg_we,
	input  logic [scfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [scfd_pkg::CFG_W-1:0]      cfg_data
);
	import scfd_pkg::*;

	scfd_word_t mid_in;
	scfd_word_t mid_out;
	logic       mid_push;
	logic       mid_full;
	logic       mid_pop;
	logic       mid_empty;
	scfd_data_t res_data;

	// front end: hunt and classify; its backpressure is the middle queue
	scfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_word (mid_in)
	);

	// only bytes inside a frame reach the middle queue
	scfd_mid_q u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (mid_push),
		.word_in  (mid_in),
		.full     (mid_full),
		.pop      (mid_pop),
		.word_out (mid_out),
		.empty    (mid_empty)
	);

	// back end: CRC, verdict and result queue
	scfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_word  (mid_out),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.res_data  (res_data)
	);

	// hunt bytes are dropped by the front end, so full only follows the queue
	assign full = mid_full;

	assign can_byte0 = res_data[0];
	assign can_byte1 = res_data[1];
	assign can_byte2 = res_data[2];
	assign can_byte3 = res_data[3];
	assign can_byte4 = res_data[4];
	assign can_byte5 = res_data[5];
	assign can_byte6 = res_data[6];
	assign can_byte7 = res_data[7];

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial CAN frame deframer. A table of directed
// frames (good frames, every header/trailer/CRC fault, start-pair corner
// cases) runs first, then random phases of well-formed, corrupted, cut-short
// frames and line noise under several register settings and flow-control
// mixes. Every accepted byte feeds a cycle-free model of the deframer; every
// popped word is checked byte by byte against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb;
	import scfd_pkg::*;

	localparam int FRAME_BYTES  = 23;
	localparam int NUM_DIR      = 20;
	localparam int NUM_PHASES   = 6;
	localparam int PHASE_BYTES  = 200;  // random bytes per phase, ~1750 with the table
	localparam int DRAIN_CYCLES = 16;   // covers a bad frame still in the pipe
	localparam int DRAIN_LIMIT  = 2000;
	localparam int TIMEOUT_NS   = 3_000_000;

	// offsets the block never checks, and a marker for "leave frame as built"
	localparam logic [POS_W-1:0] POS_SPARE0 = 5'd4;
	localparam logic [POS_W-1:0] POS_SPARE1 = 5'd5;
	localparam logic [POS_W-1:0] POS_NONE   = 5'd0;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	// link hunt state of the model
	typedef enum logic [1:0] {
		SEEK_SOF0 = 2'd0,
		SEEK_SOF1 = 2'd1,
		IN_FRAME  = 2'd2
	} seek_t;

	// bytes sent ahead of a directed frame
	typedef enum logic [1:0] {
		LEAD_NONE,
		LEAD_AA_TWICE,   // AA AA then the frame's AA 55
		LEAD_AA_BROKEN,  // AA 00 drops back to hunting
		LEAD_LONE_55     // 55 with no AA before it
	} lead_t;

	typedef struct packed {
		lead_t            lead;
		scfd_data_t       data;
		logic [POS_W-1:0] poke_pos;    // byte to overwrite, POS_NONE for none
		logic [7:0]       poke_val;
		logic             fix_crc;     // reseal CRC after the overwrite
		logic             typed;       // outcome written in the row
		logic             typed_good;  // row expects its data back
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [7:0]           rx_byte;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [7:0]           can_byte0, can_byte1, can_byte2, can_byte3;
	logic [7:0]           can_byte4, can_byte5, can_byte6, can_byte7;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	serial_can_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.empty     (empty),
		.pop       (pop),
		.can_byte0 (can_byte0),
		.can_byte1 (can_byte1),
		.can_byte2 (can_byte2),
		.can_byte3 (can_byte3),
		.can_byte4 (can_byte4),
		.can_byte5 (can_byte5),
		.can_byte6 (can_byte6),
		.can_byte7 (can_byte7),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model
	// Register copies, updated on the same edge the block takes a write.
	logic [15:0]      want_can_id;
	logic [7:0]       want_version;
	logic [7:0]       want_msg_type;

	seek_t            link_state;
	logic [POS_W-1:0] frame_pos;
	logic [15:0]      crc_acc;
	logic             frame_good;
	scfd_data_t       frame_data;
	logic [7:0]       crc_lo_seen;

	// CAN data words predicted but not yet popped, oldest first
	scfd_data_t       pending_can_words[$];

	// directed rows may pin the outcome instead of trusting the model
	bit               typed_on;
	bit               typed_good;
	scfd_data_t       typed_data;

	int               send_idle_pct;
	int               pop_stall_pct;
	int               items_sent;
	int               mismatches;

	int idle_plan_send  [NUM_PHASES] = '{0, 84, 0, 32, 84, 32};
	int idle_plan_stall [NUM_PHASES] = '{0, 0, 84, 32, 0, 32};

	// CRC-16/CCITT-FALSE, shifted one message bit at a time, msb first
	function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	// One received byte through the hunt/collect machine.
	// done: the byte closed a frame; good: that frame passed every check.
	function automatic void deframe_byte(input logic [7:0] b, output bit done, output bit good);
		done = 1'b0;
		good = 1'b0;
		case (link_state)
			SEEK_SOF1: begin
				if (b == START_BYTE1) begin
					link_state  = IN_FRAME;
					frame_pos   = POS_VERSION;
					crc_acc     = CRC_INIT;
					frame_good  = 1'b1;
					crc_lo_seen = 8'h00;
				end else begin
					// a second AA keeps us waiting for 55
					link_state = (b == START_BYTE0) ? SEEK_SOF1 : SEEK_SOF0;
				end
			end
			IN_FRAME: begin
				// no resync in here: AA/55 are ordinary frame bytes
				if (frame_pos <= POS_DATA7)
					crc_acc = crc_ccitt_byte(crc_acc, b);
				case (frame_pos)
					POS_VERSION:  if (b != want_version) frame_good = 1'b0;
					POS_MSG_TYPE: if (b != want_msg_type) frame_good = 1'b0;
					POS_LEN_LO:   if (b != PAYLOAD_LEN) frame_good = 1'b0;
					POS_LEN_HI:   if (b != 8'h00) frame_good = 1'b0;
					POS_ID_LO:    if (b != want_can_id[7:0]) frame_good = 1'b0;
					POS_ID_HI:    if (b != want_can_id[15:8]) frame_good = 1'b0;
					POS_DLC:      if (b != CAN_DLC) frame_good = 1'b0;
					POS_CRC_LO:   crc_lo_seen = b;
					POS_CRC_HI:   if ({b, crc_lo_seen} != crc_acc) frame_good = 1'b0;
					POS_TRL0:     if (b != TRAILER0) frame_good = 1'b0;
					POS_LAST:     if (b != TRAILER1) frame_good = 1'b0;
					default: ;
				endcase
				if (frame_pos >= POS_DATA0 && frame_pos <= POS_DATA7)
					frame_data[3'(frame_pos - POS_DATA0)] = b;
				if (frame_pos == POS_LAST) begin
					// hunt again whatever the verdict
					link_state = SEEK_SOF0;
					frame_pos  = POS_NONE;
					done       = 1'b1;
					good       = frame_good;
				end else begin
					frame_pos = frame_pos + 5'd1;
				end
			end
			default: link_state = (b == START_BYTE0) ? SEEK_SOF1 : SEEK_SOF0;
		endcase
	endfunction

	// --------------------------------------------------------- monitor
	// Everything is sampled at the rising edge; inputs move on the falling one.
	always @(posedge clk) begin : monitor
		bit         done;
		bit         good;
		scfd_data_t got;
		scfd_data_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_CAN_ID:   want_can_id   = cfg_data;
					CFG_VERSION:  want_version  = cfg_data[7:0];
					CFG_MSG_TYPE: want_msg_type = cfg_data[7:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				deframe_byte(rx_byte, done, good);
				if (done && typed_on) begin
					if (typed_good)
						pending_can_words.push_back(typed_data);
				end else if (good) begin
					pending_can_words.push_back(frame_data);
				end
			end
			if (pop && !empty) begin
				got = {can_byte7, can_byte6, can_byte5, can_byte4,
				       can_byte3, can_byte2, can_byte1, can_byte0};
				if (pending_can_words.size() == 0) begin
					$display("%0t: word popped with nothing pending: %h", $time, got);
					mismatches++;
				end else begin
					want = pending_can_words.pop_front();
					for (int k = 0; k < NUM_DATA; k++) begin
						if (got[k] !== want[k]) begin
							$display("%0t: can_byte%0d expected %h got %h",
							         $time, k, want[k], got[k]);
							mismatches++;
						end
					end
				end
			end
		end
	end

	// receiver side: pop decided once per falling edge
	always @(negedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	// --------------------------------------------------------- stimulus
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(15))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return START_BYTE0;
			3:       return START_BYTE1;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic frame_t reseal_crc(input frame_t f);
		logic [15:0] c;
		c = CRC_INIT;
		for (int p = POS_VERSION; p <= POS_DATA7; p++)
			c = crc_ccitt_byte(c, f[p]);
		f[POS_CRC_LO] = c[7:0];
		f[POS_CRC_HI] = c[15:8];
		return f;
	endfunction

	// well-formed frame for the current register values
	function automatic frame_t build_frame(input scfd_data_t d);
		frame_t f;
		f[0]            = START_BYTE0;
		f[1]            = START_BYTE1;
		f[POS_VERSION]  = want_version;
		f[POS_MSG_TYPE] = want_msg_type;
		f[POS_SPARE0]   = rand_byte();
		f[POS_SPARE1]   = rand_byte();
		f[POS_LEN_LO]   = PAYLOAD_LEN;
		f[POS_LEN_HI]   = 8'h00;
		f[POS_ID_LO]    = want_can_id[7:0];
		f[POS_ID_HI]    = want_can_id[15:8];
		f[POS_DLC]      = CAN_DLC;
		for (int k = 0; k < NUM_DATA; k++)
			f[POS_DATA0 + k] = d[k];
		f[POS_TRL0]     = TRAILER0;
		f[POS_LAST]     = TRAILER1;
		return reseal_crc(f);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_t f, input int nbytes);
		for (int k = 0; k < nbytes; k++)
			send_byte(f[k]);
	endtask

	// All three registers back to back; write enable stays high throughout.
	task automatic set_regs(input logic [15:0] id, input logic [7:0] ver, input logic [7:0] mt);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_CAN_ID;
		cfg_data <= id;
		@(negedge clk);
		cfg_idx  <= CFG_VERSION;
		cfg_data <= {8'($urandom_range(255)), ver};  // upper bits are don't-care
		@(negedge clk);
		cfg_idx  <= CFG_MSG_TYPE;
		cfg_data <= {8'($urandom_range(255)), mt};
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Close any open frame, wait for all words, then let the pipe go quiet.
	task automatic settle();
		int guard;
		while (link_state != SEEK_SOF0)
			send_byte(8'h00);
		push <= 1'b0;
		guard = 0;
		while (pending_can_words.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_can_words.size() != 0) begin
			$display("%0t: %0d expected word(s) never arrived, next %h",
			         $time, pending_can_words.size(), pending_can_words[0]);
			mismatches++;
			pending_can_words.delete();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Directed frames, run under reset register values (id 0x07E0, v1, t2).
	dir_row_t dir_rows [NUM_DIR] = '{
		// clean frames, data extremes
		'{LEAD_NONE, 64'h0706050403020100, POS_NONE, 8'h00, 1'b0, 1'b1, 1'b1},
		'{LEAD_NONE, 64'hFFFFFFFFFFFFFFFF, POS_NONE, 8'h00, 1'b0, 1'b1, 1'b1},
		'{LEAD_NONE, 64'h0000000000000000, POS_NONE, 8'h00, 1'b0, 1'b1, 1'b1},
		// each header/trailer field wrong, CRC resealed so only the field fails
		'{LEAD_NONE, 64'h1122334455667788, POS_VERSION,  8'h00, 1'b1, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_MSG_TYPE, 8'hFF, 1'b1, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_LEN_LO,   8'h0A, 1'b1, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_LEN_HI,   8'h01, 1'b1, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_ID_LO,    8'hE1, 1'b1, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_ID_HI,    8'h87, 1'b1, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_DLC,      8'h07, 1'b1, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_TRL0,     8'h67, 1'b0, 1'b1, 1'b0},
		'{LEAD_NONE, 64'h1122334455667788, POS_LAST,     8'hBA, 1'b0, 1'b1, 1'b0},
		// CRC faults: model decides
		'{LEAD_NONE, 64'hA1B2C3D4E5F60718, POS_CRC_LO, 8'h5A, 1'b0, 1'b0, 1'b0},
		'{LEAD_NONE, 64'hA1B2C3D4E5F60718, POS_CRC_HI, 8'hA5, 1'b0, 1'b0, 1'b0},
		'{LEAD_NONE, 64'hA1B2C3D4E5F60718, 5'(POS_DATA0 + 5'd4), 8'h3C, 1'b0, 1'b0, 1'b0},
		// start-pair corners; start bytes inside the payload are plain data
		'{LEAD_AA_TWICE,  64'h55AA55AA55AA55AA, POS_NONE, 8'h00, 1'b0, 1'b1, 1'b1},
		'{LEAD_AA_BROKEN, 64'h8040201008040201, POS_NONE, 8'h00, 1'b0, 1'b1, 1'b1},
		'{LEAD_LONE_55,   64'h7F80FE01EF10DF20, POS_NONE, 8'h00, 1'b0, 1'b1, 1'b1},
		// start bytes in both unchecked header bytes, CRC resealed over them
		'{LEAD_NONE, 64'h557F8001EFBEADDE, POS_SPARE0, 8'hAA, 1'b1, 1'b0, 1'b0},
		'{LEAD_NONE, 64'h0123456789ABCDEF, POS_SPARE1, 8'h55, 1'b1, 1'b0, 1'b0}
	};

	initial begin : stim
		dir_row_t   row;
		frame_t     f;
		scfd_data_t d;
		int         target;
		int         pick;
		int         p;
		logic [7:0] v;

		// everything driven from time zero, with reset held low first
		arst_n        = 1'b0;
		push          = 1'b0;
		rx_byte       = 8'h00;
		cfg_we        = 1'b0;
		cfg_idx       = CFG_CAN_ID;
		cfg_data      = '0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		items_sent    = 0;
		mismatches    = 0;
		typed_on      = 1'b0;
		typed_good    = 1'b0;
		typed_data    = '0;
		want_can_id   = RST_CAN_ID;
		want_version  = RST_VERSION;
		want_msg_type = RST_MSG_TYPE;
		link_state    = SEEK_SOF0;
		frame_pos     = POS_NONE;
		crc_acc       = CRC_INIT;
		frame_good    = 1'b1;
		frame_data    = '0;
		crc_lo_seen   = 8'h00;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, back to back, no idling
		for (int r = 0; r < NUM_DIR; r++) begin
			row = dir_rows[r];
			f   = build_frame(row.data);
			if (row.poke_pos != POS_NONE) begin
				f[row.poke_pos] = row.poke_val;
				if (row.fix_crc)
					f = reseal_crc(f);
			end
			typed_on   = row.typed;
			typed_good = row.typed_good;
			typed_data = row.data;
			case (row.lead)
				LEAD_AA_TWICE: begin
					send_byte(START_BYTE0);
					send_byte(START_BYTE0);
				end
				LEAD_AA_BROKEN: begin
					send_byte(START_BYTE0);
					send_byte(8'h00);
				end
				LEAD_LONE_55: send_byte(START_BYTE1);
				default: ;
			endcase
			send_frame(f, FRAME_BYTES);
			typed_on = 1'b0;
		end
		settle();

		// random phases: new registers and a new flow-control mix each time
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: ;  // keep reset values
				1: set_regs(16'h0000, 8'h00, 8'h00);
				2: set_regs(16'hFFFF, 8'hFF, 8'hFF);
				// start-pair values in the header fields
				4: set_regs(16'($urandom_range(16'hFFFF)), START_BYTE0, START_BYTE1);
				default: set_regs(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
				                  8'($urandom_range(255)));
			endcase
			send_idle_pct = idle_plan_send[ph];
			pop_stall_pct = idle_plan_stall[ph];
			target = items_sent + PHASE_BYTES;
			while (items_sent < target) begin
				for (int k = 0; k < NUM_DATA; k++)
					d[k] = rand_byte();
				f    = build_frame(d);
				pick = $urandom_range(99);
				if (pick < 60) begin
					send_frame(f, FRAME_BYTES);
				end else if (pick < 75) begin
					// one byte damaged, CRC sometimes resealed over it
					p = $urandom_range(POS_LAST, POS_VERSION);
					v = rand_byte();
					f[p] = (v == f[p]) ? ~v : v;
					if (p <= POS_DATA7 && $urandom_range(1))
						f = reseal_crc(f);
					send_frame(f, FRAME_BYTES);
				end else if (pick < 88) begin
					// line noise, heavy on start bytes
					repeat ($urandom_range(5, 1)) begin
						case ($urandom_range(5))
							0, 1:    send_byte(START_BYTE0);
							2:       send_byte(START_BYTE1);
							default: send_byte(8'($urandom_range(255)));
						endcase
					end
				end else begin
					// cut short: the next frame lands inside this one
					send_frame(f, $urandom_range(FRAME_BYTES - 1, 1));
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
